/* rtl/lws_pkg.sv */
// ----------------------------------------------------------------------------
// lws_pkg
// Shared constants, codes and controller/datapath types for the lattice walk
// step engine.
// ----------------------------------------------------------------------------
package lws_pkg;

    // Lattice geometry
    localparam int GRID_HALF  = 16;
    localparam int DIRECTIONS = 6;
    localparam int SPAN       = 2 * GRID_HALF;
    localparam int COORD_W    = $clog2(SPAN);
    localparam int ROWS       = SPAN * SPAN;
    localparam int ROW_AW     = $clog2(ROWS);
    localparam int ORIGIN_ROW = GRID_HALF * SPAN + GRID_HALF;

    // Field widths
    localparam int RAND_W  = 32;
    localparam int HEAD_W  = 5;
    localparam int DIR_W   = 3;
    localparam int COUNT_W = 16;

    // Weights: free site vs occupied site in self-avoiding mode
    localparam longint unsigned FREE_WEIGHT = 64'd100000000;
    localparam longint unsigned TOTAL_MAX   = FREE_WEIGHT * DIRECTIONS;
    localparam int TOTAL_W = $clog2(TOTAL_MAX + 1);
    localparam int PROD_W  = RAND_W + TOTAL_W;
    localparam int NFREE_W = $clog2(DIRECTIONS + 1);

    // Sequencer counter and neighbor row slots
    localparam int CNT_W     = 3;
    localparam int READ_ROWS = 5;

    localparam logic [CNT_W-1:0] SLOT_HEAD = 3'd0;
    localparam logic [CNT_W-1:0] SLOT_YP   = 3'd1;
    localparam logic [CNT_W-1:0] SLOT_YM   = 3'd2;
    localparam logic [CNT_W-1:0] SLOT_ZP   = 3'd3;
    localparam logic [CNT_W-1:0] SLOT_ZM   = 3'd4;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_PX = 3'd0;
    localparam logic [DIR_W-1:0] DIR_MX = 3'd1;
    localparam logic [DIR_W-1:0] DIR_PY = 3'd2;
    localparam logic [DIR_W-1:0] DIR_MY = 3'd3;
    localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
    localparam logic [DIR_W-1:0] DIR_MZ = 3'd5;
    localparam logic [DIR_W-1:0] DIR_LAST = DIR_MZ;

    // Item function codes
    localparam logic FUNC_RESTART = 1'b0;
    localparam logic FUNC_STEP    = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WEIGH,
        ST_MULT,
        ST_PICK,
        ST_WR_RD,
        ST_WRITE,
        ST_DONE
    } lws_state_t;

    typedef struct packed {
        logic              accept;
        logic              restart;
        logic              clr_we;
        logic [ROW_AW-1:0] clr_row;
        logic              rd_en;
        logic [CNT_W-1:0]  rd_slot;
        logic              cap_en;
        logic [CNT_W-1:0]  cap_slot;
        logic              weigh;
        logic              mult;
        logic              pick;
        logic [DIR_W-1:0]  pick_k;
        logic              wr_rd;
        logic              wr_en;
        logic              finish;
    } lws_cmd_t;

    typedef struct packed {
        logic edge_hit;
        logic pick_hit;
        logic move_off;
    } lws_status_t;

endpackage

/* rtl/lws_ram.sv */
// ----------------------------------------------------------------------------
// lws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lws_ctrl.sv */
// ----------------------------------------------------------------------------
// lws_ctrl
// Sequencer: map clear sweep, neighbor reads, weighting, pick, write-back.
// ----------------------------------------------------------------------------
module lws_ctrl
    import lws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        func,
    input  lws_status_t status,
    output lws_cmd_t    cmd,
    output logic        busy
);

    lws_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ROW_AW-1:0] clr_reg, clr_next;
    logic              report_reg, report_next;
    logic              clr_last;
    logic              accept;

    assign clr_last = (clr_reg == ROW_AW'(ROWS - 1));
    assign accept   = (state_reg == ST_IDLE) && start;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = report_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (func == FUNC_RESTART) ? ST_CLEAR : ST_READ;
                end
            end
            ST_READ:
            begin
                if (cnt_reg == CNT_W'(READ_ROWS))
                begin
                    state_next = ST_WEIGH;
                end
            end
            ST_WEIGH: state_next = ST_MULT;
            ST_MULT:  state_next = status.edge_hit ? ST_DONE : ST_PICK;
            ST_PICK:
            begin
                if (status.pick_hit || (cnt_reg == CNT_W'(DIRECTIONS - 1)))
                begin
                    state_next = ST_WR_RD;
                end
            end
            ST_WR_RD: state_next = status.move_off ? ST_DONE : ST_WRITE;
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // counters
    always_comb
    begin
        cnt_next    = cnt_reg;
        clr_next    = '0;
        report_next = report_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_last ? '0 : clr_reg + 1'b1;
                if (clr_last)
                begin
                    report_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (start && (func == FUNC_RESTART))
                begin
                    report_next = 1'b1;
                end
            end
            ST_READ: cnt_next = cnt_reg + 1'b1;
            ST_MULT: cnt_next = '0;
            ST_PICK: cnt_next = cnt_reg + 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.restart  = accept && (func == FUNC_RESTART);
        cmd.clr_row  = clr_reg;
        cmd.rd_slot  = cnt_reg;
        cmd.cap_slot = cnt_reg - 1'b1;
        cmd.pick_k   = DIR_W'(cnt_reg);
        case (state_reg)
            ST_CLEAR: cmd.clr_we = 1'b1;
            ST_READ:
            begin
                cmd.rd_en  = (cnt_reg < CNT_W'(READ_ROWS));
                cmd.cap_en = (cnt_reg != '0);
            end
            ST_WEIGH: cmd.weigh  = 1'b1;
            ST_MULT:  cmd.mult   = 1'b1;
            ST_PICK:  cmd.pick   = 1'b1;
            ST_WR_RD: cmd.wr_rd  = 1'b1;
            ST_WRITE: cmd.wr_en  = 1'b1;
            ST_DONE:  cmd.finish = 1'b1;
            default:  cmd.finish = 1'b0;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cnt_reg    <= '0;
            clr_reg    <= '0;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            clr_reg    <= clr_next;
            report_reg <= report_next;
        end
    end

endmodule

/* rtl/lws_datapath.sv */
// ----------------------------------------------------------------------------
// lws_datapath
// Head position, occupancy rows, weights, pick arithmetic and result regs.
// ----------------------------------------------------------------------------
module lws_datapath
    import lws_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lws_cmd_t                  cmd,
    output lws_status_t               status,
    input  logic [RAND_W-1:0]         random_fraction,
    input  logic                      cfg_we,
    input  logic                      cfg_data,
    output logic                      done,
    output logic signed [HEAD_W-1:0]  head_x,
    output logic signed [HEAD_W-1:0]  head_y,
    output logic signed [HEAD_W-1:0]  head_z,
    output logic [DIR_W-1:0]          chosen_direction,
    output logic                      trapped,
    output logic                      off_grid,
    output logic [COUNT_W-1:0]        chain_length
);

    function automatic logic [ROW_AW-1:0] row_of(input logic [COORD_W-1:0] uy,
                                                 input logic [COORD_W-1:0] uz);
        int r;
        r = int'(uz) * SPAN + int'(uy);
        return r[ROW_AW-1:0];
    endfunction

    function automatic logic bit_of(input logic [SPAN-1:0]    row,
                                    input logic [COORD_W-1:0] idx);
        return (int'(idx) < SPAN) ? row[idx] : 1'b0;
    endfunction

    function automatic logic [HEAD_W-1:0] to_coord(input logic [COORD_W-1:0] u);
        int v;
        v = int'(u) - GRID_HALF;
        return v[HEAD_W-1:0];
    endfunction

    localparam logic [COORD_W-1:0] U_ORIGIN = COORD_W'(GRID_HALF);
    localparam logic [COORD_W-1:0] U_LOW    = COORD_W'(1);
    localparam logic [COORD_W-1:0] U_HIGH   = COORD_W'(SPAN - 1);

    // state
    logic                    mode_reg;
    logic [COORD_W-1:0]      ux_reg, uy_reg, uz_reg;
    logic [COUNT_W-1:0]      count_reg;
    // per-item working registers
    logic [RAND_W-1:0]       rand_reg;
    logic [DIRECTIONS-1:0]   used_reg;
    logic [DIRECTIONS-1:0]   free_reg;
    logic [TOTAL_W-1:0]      total_reg;
    logic [TOTAL_W-1:0]      q_reg;
    logic [TOTAL_W-1:0]      cum_reg;
    logic                    edge_reg;
    logic [DIR_W-1:0]        dir_reg;
    logic                    trap_reg;
    logic                    off_reg;
    // results
    logic                    done_reg;
    logic [HEAD_W-1:0]       hx_reg, hy_reg, hz_reg;
    logic [DIR_W-1:0]        dir_out_reg;
    logic                    trap_out_reg, off_out_reg;
    logic [COUNT_W-1:0]      len_out_reg;

    logic [COORD_W-1:0]      ux_p, ux_m, uy_p, uy_m, uz_p, uz_m;
    logic [ROW_AW-1:0]       rd_row, tgt_row;
    logic [COORD_W-1:0]      tgt_bit;
    logic [COORD_W-1:0]      nx, ny, nz;
    logic                    move_off;
    logic [SPAN-1:0]         rdata;
    logic                    mem_we, mem_re;
    logic [ROW_AW-1:0]       mem_waddr, mem_raddr;
    logic [SPAN-1:0]         mem_wdata;
    logic [DIRECTIONS-1:0]   free_w;
    logic [NFREE_W-1:0]      nfree;
    logic                    edge_w;
    logic [PROD_W-1:0]       prod;
    logic [TOTAL_W-1:0]      cum_w;

    assign ux_p = ux_reg + 1'b1;
    assign ux_m = ux_reg - 1'b1;
    assign uy_p = uy_reg + 1'b1;
    assign uy_m = uy_reg - 1'b1;
    assign uz_p = uz_reg + 1'b1;
    assign uz_m = uz_reg - 1'b1;

    always_comb
    begin
        case (cmd.rd_slot)
            SLOT_HEAD: rd_row = row_of(uy_reg, uz_reg);
            SLOT_YP:   rd_row = row_of(uy_p, uz_reg);
            SLOT_YM:   rd_row = row_of(uy_m, uz_reg);
            SLOT_ZP:   rd_row = row_of(uy_reg, uz_p);
            SLOT_ZM:   rd_row = row_of(uy_reg, uz_m);
            default:   rd_row = row_of(uy_reg, uz_reg);
        endcase
    end

    // target of the chosen move
    always_comb
    begin
        nx       = ux_reg;
        ny       = uy_reg;
        nz       = uz_reg;
        move_off = 1'b0;
        case (dir_reg)
            DIR_PX:
            begin
                nx       = ux_p;
                move_off = (ux_reg == U_HIGH);
            end
            DIR_MX:
            begin
                nx       = ux_m;
                move_off = (ux_reg == U_LOW);
            end
            DIR_PY:
            begin
                ny       = uy_p;
                move_off = (uy_reg == U_HIGH);
            end
            DIR_MY:
            begin
                ny       = uy_m;
                move_off = (uy_reg == U_LOW);
            end
            DIR_PZ:
            begin
                nz       = uz_p;
                move_off = (uz_reg == U_HIGH);
            end
            DIR_MZ:
            begin
                nz       = uz_m;
                move_off = (uz_reg == U_LOW);
            end
            default: move_off = 1'b0;
        endcase
    end

    assign tgt_row = row_of(ny, nz);
    assign tgt_bit = nx;

    // occupancy memory: clear sweep, neighbor reads, read-modify-write mark
    assign mem_we    = cmd.clr_we || cmd.wr_en;
    assign mem_waddr = cmd.clr_we ? cmd.clr_row : tgt_row;
    assign mem_re    = cmd.rd_en || cmd.wr_rd;
    assign mem_raddr = cmd.wr_rd ? tgt_row : rd_row;

    always_comb
    begin
        if (cmd.clr_we)
        begin
            mem_wdata = (cmd.clr_row == ROW_AW'(ORIGIN_ROW)) ?
                        (SPAN'(1) << U_ORIGIN) : '0;
        end
        else
        begin
            mem_wdata = rdata | (SPAN'(1) << tgt_bit);
        end
    end

    lws_ram #(
        .WIDTH (SPAN),
        .DEPTH (ROWS)
    ) u_occ_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    // weighting
    assign free_w = mode_reg ? ~used_reg : '0;
    assign nfree  = NFREE_W'($countones(free_w));
    assign edge_w = mode_reg &&
                    ((ux_reg == U_LOW) || (ux_reg == U_HIGH) ||
                     (uy_reg == U_LOW) || (uy_reg == U_HIGH) ||
                     (uz_reg == U_LOW) || (uz_reg == U_HIGH));

    assign prod  = PROD_W'(rand_reg) * PROD_W'(total_reg);
    assign cum_w = cum_reg + (free_reg[cmd.pick_k] ? TOTAL_W'(FREE_WEIGHT) : TOTAL_W'(1));

    assign status.edge_hit = edge_reg;
    assign status.pick_hit = (q_reg < cum_w);
    assign status.move_off = move_off;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b1;
            ux_reg    <= U_ORIGIN;
            uy_reg    <= U_ORIGIN;
            uz_reg    <= U_ORIGIN;
            count_reg <= COUNT_W'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (cmd.restart)
            begin
                ux_reg    <= U_ORIGIN;
                uy_reg    <= U_ORIGIN;
                uz_reg    <= U_ORIGIN;
                count_reg <= COUNT_W'(1);
            end
            if (cmd.wr_en)
            begin
                ux_reg <= nx;
                uy_reg <= ny;
                uz_reg <= nz;
                if (count_reg != '1)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rand_reg <= random_fraction;
            dir_reg  <= DIR_PX;
            trap_reg <= 1'b0;
            off_reg  <= 1'b0;
            used_reg <= '0;
        end
        if (cmd.cap_en)
        begin
            case (cmd.cap_slot)
                SLOT_HEAD:
                begin
                    used_reg[DIR_PX] <= bit_of(rdata, ux_p);
                    used_reg[DIR_MX] <= bit_of(rdata, ux_m);
                end
                SLOT_YP: used_reg[DIR_PY] <= bit_of(rdata, ux_reg);
                SLOT_YM: used_reg[DIR_MY] <= bit_of(rdata, ux_reg);
                SLOT_ZP: used_reg[DIR_PZ] <= bit_of(rdata, ux_reg);
                SLOT_ZM: used_reg[DIR_MZ] <= bit_of(rdata, ux_reg);
                default: used_reg <= used_reg;
            endcase
        end
        if (cmd.weigh)
        begin
            free_reg  <= free_w;
            total_reg <= TOTAL_W'(nfree) * TOTAL_W'(FREE_WEIGHT)
                         + TOTAL_W'(DIRECTIONS) - TOTAL_W'(nfree);
            edge_reg  <= edge_w;
            trap_reg  <= mode_reg && !edge_w && (used_reg == '1);
        end
        if (cmd.mult)
        begin
            q_reg   <= prod[PROD_W-1:RAND_W];
            cum_reg <= '0;
            if (edge_reg)
            begin
                off_reg <= 1'b1;
            end
            else
            begin
                dir_reg <= DIR_LAST;
            end
        end
        if (cmd.pick)
        begin
            cum_reg <= cum_w;
            if (status.pick_hit)
            begin
                dir_reg <= cmd.pick_k;
            end
        end
        if (cmd.wr_rd && move_off)
        begin
            off_reg <= 1'b1;
        end
        if (cmd.finish)
        begin
            hx_reg       <= to_coord(ux_reg);
            hy_reg       <= to_coord(uy_reg);
            hz_reg       <= to_coord(uz_reg);
            dir_out_reg  <= dir_reg;
            trap_out_reg <= trap_reg;
            off_out_reg  <= off_reg;
            len_out_reg  <= count_reg;
        end
    end

    assign done             = done_reg;
    assign head_x           = hx_reg;
    assign head_y           = hy_reg;
    assign head_z           = hz_reg;
    assign chosen_direction = dir_out_reg;
    assign trapped          = trap_out_reg;
    assign off_grid         = off_out_reg;
    assign chain_length     = len_out_reg;

endmodule

/* rtl/lattice_walk_step_engine.sv */
// ----------------------------------------------------------------------------
// lattice_walk_step_engine
// Grows a chain on a 3-D cubic lattice, at most one site per step
// transaction, with phantom or self-avoiding direction weighting.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ------------------------------------
//  command   start, busy (accept when     func, random_fraction
//            start && !busy)
//  result    done (one-cycle strobe)      head_x/y/z, chosen_direction,
//                                         trapped, off_grid, chain_length
//  config    cfg_valid, cfg_ready         cfg_data (chain_mode)
//
//  Sequence of a step: five neighbor row reads through the single read port of
//  the occupancy RAM, weigh, multiply, then either a stop at the rim or a pick
//  that walks the cumulative weights one direction per cycle, a read of the
//  target row and, when the move stays on the grid, the mark write; done
//  follows from the DONE state.
//  Restart clears the occupancy RAM one row per cycle, all ROWS (1024) rows,
//  and raises done once the last row is cleared.
//  After reset the same clearing pass runs with busy high and without done;
//  config writes are taken only while busy is low.
//  The result holds on the ports until the next done; the receiver cannot stall.
//
module lattice_walk_step_engine
    import lws_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // command
    input  logic                      start,
    output logic                      busy,
    input  logic                      func,
    input  logic [RAND_W-1:0]         random_fraction,
    // configuration
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_data,
    // result
    output logic                      done,
    output logic signed [HEAD_W-1:0]  head_x,
    output logic signed [HEAD_W-1:0]  head_y,
    output logic signed [HEAD_W-1:0]  head_z,
    output logic [DIR_W-1:0]          chosen_direction,
    output logic                      trapped,
    output logic                      off_grid,
    output logic [COUNT_W-1:0]        chain_length
);

    lws_cmd_t    cmd;
    lws_status_t status;

    // chain_mode is a single flop; writes wait until no transaction or
    // clear pass is in flight
    assign cfg_ready = !busy;

    // sequencer: clear sweep, reads, pick loop, write-back
    lws_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // head, occupancy RAM, weight arithmetic, result registers
    lws_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .random_fraction  (random_fraction),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .done             (done),
        .head_x           (head_x),
        .head_y           (head_y),
        .head_z           (head_z),
        .chosen_direction (chosen_direction),
        .trapped          (trapped),
        .off_grid         (off_grid),
        .chain_length     (chain_length)
    );

    // an accepted transaction keeps the block busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // the result strobe comes as the sequencer returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

    // a trapped walk is away from the edge, so its move cannot leave the grid
    a_trap_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(trapped && off_grid))
        else $error("trapped and off_grid together");

    // the origin is always placed
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (chain_length != '0))
        else $error("chain_length is zero");

endmodule
